[rtl/lpntc_pkg.sv]
// Shared types and codes for the length-prefixed name table checker.
package lpntc_pkg;

  // Byte roles reported with every result
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_LEN_HI  = 3'd1;
  localparam logic [2:0] ROLE_LEN_LO  = 3'd2;
  localparam logic [2:0] ROLE_NAME    = 3'd3;
  localparam logic [2:0] ROLE_IGNORED = 3'd4;

  // Error codes, first one found in a frame is latched
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_VERSION  = 3'd1;
  localparam logic [2:0] ERR_RESERVED = 3'd2;
  localparam logic [2:0] ERR_EMPTY    = 3'd3;
  localparam logic [2:0] ERR_NUL      = 3'd4;
  localparam logic [2:0] ERR_TRUNC    = 3'd5;
  localparam logic [2:0] ERR_TRAIL    = 3'd6;

  // Version expected after reset
  localparam logic [7:0] VERSION_RESET = 8'd1;

  // Result of one byte
  typedef struct packed {
    logic [2:0]  byte_role;
    logic        section;
    logic [15:0] record_index;
    logic [7:0]  name_byte;
    logic        name_end;
    logic        frame_done;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [15:0] flag_total;
    logic [15:0] value_total;
  } result_t;

endpackage

[rtl/length_prefixed_name_table_checker.sv]
// Top level of the length-prefixed name table checker with result register.
//
//   Channel   Dir  Handshake                    Payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  one frame byte, tlast = frame end
//   m_axis    out  m_axis_tvalid/m_axis_tready  one result per byte, tlast = frame done
//   cfg       in   cfg_valid_i/cfg_ready_o      format version (8 bits)
//
// One byte is taken per cycle unless the result register stalls; its result is
// captured in the result register on acceptance. The parser state updates in
// the same cycle as the request, so throughput is set only by the result
// register draining. A stalled result blocks new requests only while the
// result register is full and not being taken. Reset clears all frame state
// and sets the version to 1; configuration writes are taken at any time.
module length_prefixed_name_table_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Byte input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  // Result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] section, [16:1] record_index, [24:17] name_byte, [25] name_end,
  // [26] frame_ok, [29:27] error_code, [45:30] flag_total,
  // [61:46] value_total, [63:62] zero
  output logic [63:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_role
  output logic        m_axis_tlast,   // frame_done
  // Configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic                out_valid_q;
  lpntc_pkg::result_t  out_res_q;
  lpntc_pkg::result_t  step_res;
  logic [7:0]          version_q;
  logic                accept;

  // Take a request whenever the result register is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Hold the expected version
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= lpntc_pkg::VERSION_RESET;
    end else if (cfg_valid_i) begin
      version_q <= cfg_data_i;
    end
  end

  lpntc_step u_step (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .data_byte_i      (s_axis_tdata),
    .frame_end_i      (s_axis_tlast),
    .format_version_i (version_q),
    .result_o         (step_res)
  );

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.byte_role;
  assign m_axis_tlast  = out_res_q.frame_done;
  assign m_axis_tdata  = {2'b00,
                          out_res_q.value_total,
                          out_res_q.flag_total,
                          out_res_q.error_code,
                          out_res_q.frame_ok,
                          out_res_q.name_end,
                          out_res_q.name_byte,
                          out_res_q.record_index,
                          out_res_q.section};

`ifndef SYNTHESIS
  // An accepted byte always leaves a result behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted byte produced no result");

  // Success is reported only on a frame's last byte, with no error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.frame_ok) |->
      (out_res_q.frame_done && (out_res_q.error_code == lpntc_pkg::ERR_NONE)))
    else $error("frame_ok without clean frame end");

  // A frame end with no latched error must be a success
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.frame_done &&
     (out_res_q.error_code == lpntc_pkg::ERR_NONE)) |-> out_res_q.frame_ok)
    else $error("clean frame end not reported as ok");

  // Name end marks only name bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_res_q.name_end) |->
      (out_res_q.byte_role == lpntc_pkg::ROLE_NAME))
    else $error("name_end on non-name byte");

  // Ignored bytes only follow an error or finished records
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_res_q.byte_role == lpntc_pkg::ROLE_IGNORED)) |->
      (out_res_q.error_code != lpntc_pkg::ERR_NONE))
    else $error("ignored byte without error");
`endif

endmodule

[rtl/lpntc_step.sv]
// Frame parser state and per-byte classification logic.
module lpntc_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                frame_end_i,
  input  logic [7:0]          format_version_i,
  output lpntc_pkg::result_t  result_o
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN_HI = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_NAME   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  localparam logic [2:0] HDR_LAST  = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [15:0] flag_cnt_q, flag_cnt_d;
  logic [15:0] value_cnt_q, value_cnt_d;
  logic        section_q, section_d;
  logic [15:0] records_q, records_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [2:0]  first_err_q, first_err_d;

  // Record seek: next record, next section or done
  logic        seek_sec_in;
  logic [15:0] seek_rec_in;
  logic [15:0] seek_vcnt;
  logic        seek_sec;
  logic [15:0] seek_rec;
  logic [2:0]  seek_phase;

  always_comb begin
    if (phase_q == PH_HEADER) begin
      seek_sec_in = 1'b0;
      seek_rec_in = '0;
      seek_vcnt   = {value_cnt_q[7:0], data_byte_i};
    end else begin
      seek_sec_in = section_q;
      seek_rec_in = records_q + 16'd1;
      seek_vcnt   = value_cnt_q;
    end
    seek_sec = seek_sec_in;
    seek_rec = seek_rec_in;
    if (!seek_sec_in && (seek_rec_in >= flag_cnt_q)) begin
      seek_sec = 1'b1;
      seek_rec = '0;
    end
    if (seek_sec && (seek_rec >= seek_vcnt)) begin
      seek_phase = PH_DONE;
    end else begin
      seek_phase = PH_LEN_HI;
    end
  end

  // Classify the byte and compute the next frame state
  logic       raise;
  logic [2:0] raise_code;
  logic [15:0] len_word;

  assign len_word = {len_hi_q, data_byte_i};

  always_comb begin
    phase_d     = phase_q;
    hdr_pos_d   = hdr_pos_q;
    flag_cnt_d  = flag_cnt_q;
    value_cnt_d = value_cnt_q;
    section_d   = section_q;
    records_d   = records_q;
    left_d      = left_q;
    len_hi_d    = len_hi_q;
    raise       = 1'b0;
    raise_code  = lpntc_pkg::ERR_NONE;

    result_o              = '0;
    result_o.byte_role    = lpntc_pkg::ROLE_IGNORED;
    result_o.section      = section_q;
    result_o.record_index = records_q;

    case (phase_q)
      PH_HEADER: begin
        result_o.byte_role    = lpntc_pkg::ROLE_HEADER;
        result_o.section      = 1'b0;
        result_o.record_index = '0;
        case (hdr_pos_q)
          3'd0: begin
            if (data_byte_i != format_version_i) begin
              raise      = 1'b1;
              raise_code = lpntc_pkg::ERR_VERSION;
            end
          end
          3'd1: begin
            if (data_byte_i != 8'd0) begin
              raise      = 1'b1;
              raise_code = lpntc_pkg::ERR_RESERVED;
            end
          end
          3'd2, 3'd3: flag_cnt_d = {flag_cnt_q[7:0], data_byte_i};
          default: value_cnt_d = {value_cnt_q[7:0], data_byte_i};
        endcase
        if (!raise) begin
          if (hdr_pos_q >= HDR_LAST) begin
            hdr_pos_d = '0;
            section_d = seek_sec;
            records_d = seek_rec;
            phase_d   = seek_phase;
          end else begin
            hdr_pos_d = hdr_pos_q + 3'd1;
          end
        end
      end
      PH_LEN_HI: begin
        result_o.byte_role = lpntc_pkg::ROLE_LEN_HI;
        len_hi_d           = data_byte_i;
        phase_d            = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        result_o.byte_role = lpntc_pkg::ROLE_LEN_LO;
        left_d             = len_word;
        if (len_word == 16'd0) begin
          raise      = 1'b1;
          raise_code = lpntc_pkg::ERR_EMPTY;
        end else begin
          phase_d = PH_NAME;
        end
      end
      PH_NAME: begin
        result_o.byte_role = lpntc_pkg::ROLE_NAME;
        result_o.name_byte = data_byte_i;
        if (data_byte_i == 8'd0) begin
          raise      = 1'b1;
          raise_code = lpntc_pkg::ERR_NUL;
        end else begin
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            result_o.name_end = 1'b1;
            section_d         = seek_sec;
            records_d         = seek_rec;
            phase_d           = seek_phase;
          end
        end
      end
      PH_DONE: begin
        raise      = 1'b1;
        raise_code = lpntc_pkg::ERR_TRAIL;
      end
      default: begin
        result_o.byte_role = lpntc_pkg::ROLE_IGNORED;
      end
    endcase

    // Latch only the first error of the frame
    first_err_d = first_err_q;
    if (raise) begin
      phase_d = PH_ERROR;
      if (first_err_q == lpntc_pkg::ERR_NONE) begin
        first_err_d = raise_code;
      end
    end

    // Close the frame on its last byte
    if (frame_end_i) begin
      if ((first_err_d == lpntc_pkg::ERR_NONE) && (phase_d != PH_DONE)) begin
        first_err_d = lpntc_pkg::ERR_TRUNC;
      end
      result_o.frame_done = 1'b1;
      result_o.frame_ok   = (first_err_d == lpntc_pkg::ERR_NONE);
    end
    result_o.error_code  = first_err_d;
    result_o.flag_total  = flag_cnt_d;
    result_o.value_total = value_cnt_d;
  end

  // Advance the frame state on each accepted byte, rearm after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_pos_q   <= '0;
      flag_cnt_q  <= '0;
      value_cnt_q <= '0;
      section_q   <= 1'b0;
      records_q   <= '0;
      left_q      <= '0;
      len_hi_q    <= '0;
      first_err_q <= lpntc_pkg::ERR_NONE;
    end else if (accept_i) begin
      if (frame_end_i) begin
        phase_q     <= PH_HEADER;
        hdr_pos_q   <= '0;
        flag_cnt_q  <= '0;
        value_cnt_q <= '0;
        section_q   <= 1'b0;
        records_q   <= '0;
        left_q      <= '0;
        len_hi_q    <= '0;
        first_err_q <= lpntc_pkg::ERR_NONE;
      end else begin
        phase_q     <= phase_d;
        hdr_pos_q   <= hdr_pos_d;
        flag_cnt_q  <= flag_cnt_d;
        value_cnt_q <= value_cnt_d;
        section_q   <= section_d;
        records_q   <= records_d;
        left_q      <= left_d;
        len_hi_q    <= len_hi_d;
        first_err_q <= first_err_d;
      end
    end
  end

endmodule
